### rtl/dis_pkg.sv
// Shared types, constants and helpers for the distinct index sampler.
package dis_pkg;

    localparam int LIST_DEPTH  = 134;
    localparam int ADDR_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W       = 20;
    localparam int WORD_W      = 32;
    localparam int OUT_CNT_W   = 8;
    localparam logic [IDX_W-1:0] LIMIT_RESET = IDX_W'(24646);

    typedef struct packed {
        logic [WORD_W-1:0] random_word;
        logic              restart;
    } t_dis_in;

    typedef struct packed {
        logic                 accepted;
        logic [IDX_W-1:0]     candidate_index;
        logic [OUT_CNT_W-1:0] stored_count;
        logic                 list_full;
    } t_dis_out;

    typedef enum logic [1:0] {
        DIS_IDLE,
        DIS_SCAN,
        DIS_COMMIT
    } t_dis_state;

    typedef struct packed {
        logic load;     // capture a new request
        logic scan_rd;  // read the list entry at the scan pointer
        logic commit;   // decide, store and present the result
    } t_dis_cmd;

    typedef struct packed {
        logic scan_done;  // scan pointer reached the fill count
        logic rd_pend;    // a read is still waiting for its compare
        logic out_free;   // output register can take a result
    } t_dis_stat;

    // all ones up to and including the highest set bit of n
    function automatic logic [IDX_W-1:0] length_mask(input logic [IDX_W-1:0] n);
        logic [IDX_W-1:0] m;
        m = n;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        return m;
    endfunction

endpackage

### rtl/dis_ctrl.sv
// Sequencing state machine: accept, scan the stored list, commit the result.
module dis_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dis_pkg::t_dis_stat i_stat,
    output dis_pkg::t_dis_cmd  o_cmd,
    output logic               o_in_ready
);
    import dis_pkg::*;

    t_dis_state r_state;
    t_dis_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIS_IDLE: begin
                if (i_in_valid) n_state = DIS_SCAN;
            end
            DIS_SCAN: begin
                if (i_stat.scan_done && !i_stat.rd_pend) n_state = DIS_COMMIT;
            end
            DIS_COMMIT: begin
                if (i_stat.out_free) n_state = DIS_IDLE;
            end
            default: n_state = DIS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            DIS_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            DIS_SCAN: begin
                o_cmd.scan_rd = !i_stat.scan_done;
            end
            DIS_COMMIT: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/dis_datapath.sv
// List memory, fill count, candidate compare and output register.
module dis_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dis_pkg::t_dis_cmd         i_cmd,
    output dis_pkg::t_dis_stat        o_stat,
    input  dis_pkg::t_dis_in          i_in_data,
    input  logic                      i_cfg_valid,
    input  logic [dis_pkg::IDX_W-1:0] i_cfg_data,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output dis_pkg::t_dis_out         o_out_data
);
    import dis_pkg::*;

    logic [IDX_W-1:0] r_mem [LIST_DEPTH];

    logic [IDX_W-1:0] r_limit;
    logic [IDX_W-1:0] r_mask;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr;
    logic [IDX_W-1:0] r_cand;
    logic             r_cand_ok;
    logic             r_dup;
    logic             r_pend;
    logic [IDX_W-1:0] r_rdata;
    logic             r_out_valid;
    t_dis_out         r_out;

    logic [IDX_W-1:0] n_cand;
    logic             n_take;
    logic [CNT_W-1:0] n_count;

    assign n_cand = i_in_data.random_word[IDX_W-1:0] & r_mask;
    assign n_take = r_cand_ok && !r_dup && (r_count < CNT_W'(LIST_DEPTH));
    assign n_count = n_take ? r_count + 1'b1 : r_count;

    assign o_stat.scan_done = (r_addr == r_count);
    assign o_stat.rd_pend   = r_pend;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_mask  <= length_mask(LIMIT_RESET);
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
            r_mask  <= length_mask(i_cfg_data);
        end
    end

    // list memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_take) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_cand;
        end
        if (i_cmd.scan_rd) begin
            r_rdata <= r_mem[r_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_addr <= '0;
                r_dup  <= 1'b0;
                if (i_in_data.restart) r_count <= '0;
            end else begin
                if (i_cmd.scan_rd) r_addr <= r_addr + 1'b1;
                if (r_pend && (r_rdata == r_cand)) r_dup <= 1'b1;
                if (i_cmd.commit) r_count <= n_count;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand    <= n_cand;
            r_cand_ok <= (n_cand < r_limit);
        end
        if (i_cmd.commit) begin
            r_out.accepted        <= n_take;
            r_out.candidate_index <= r_cand;
            r_out.stored_count    <= OUT_CNT_W'(n_count);
            r_out.list_full       <= (n_count == CNT_W'(LIST_DEPTH));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("fill count above list depth");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a pending output");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_take) |=> (r_count == $past(r_count) + 1'b1))
        else $error("stored request did not advance the count");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> (r_addr < r_count))
        else $error("scan read past the fill count");

endmodule

### rtl/distinct_index_sampler.sv
// Top level of the distinct index sampler: controller plus datapath.
// Each request scans the stored entries up to the fill count (taken after any restart),
// then commits; output stalls hold the commit. A new request is taken only while idle,
// after the previous result has been committed; one stored entry is compared per cycle.
// Reset (synchronous, active low) empties the list, sets the limit to 24646
// and clears the output; the memory itself is not cleared, the fill count bounds reads.
module distinct_index_sampler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  dis_pkg::t_dis_in          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output dis_pkg::t_dis_out         o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dis_pkg::IDX_W-1:0] i_cfg_data
);
    import dis_pkg::*;

    t_dis_cmd  w_cmd;
    t_dis_stat w_stat;
    logic      w_in_ready;

    dis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    dis_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall  = !w_in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

### tb/tb_distinct_index_sampler.sv
// Self-checking testbench for the distinct index sampler: directed, full-list and random runs.
module tb_distinct_index_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    import dis_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int RST_CYCLES = 5;
    localparam int TAIL_WAIT  = LIST_DEPTH + 16;
    localparam logic [IDX_W-1:0] LIMIT_MAX = '1;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_dis_in          i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_dis_out         o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_data  = '0;

    // predictor state
    logic [IDX_W-1:0] shadow_list [LIST_DEPTH];
    int               shadow_count;
    logic [IDX_W-1:0] shadow_limit;

    t_dis_out expected_samples [$];
    int       mismatch_count = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    distinct_index_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic void clear_shadow();
        for (int k = 0; k < LIST_DEPTH; k++) begin
            shadow_list[k] = '1;
        end
        shadow_count = 0;
    endfunction

    function automatic t_dis_out predict_sample(input t_dis_in req);
        t_dis_out         res;
        logic [IDX_W-1:0] mask;
        logic [IDX_W-1:0] cand;
        logic             hit;
        mask = '0;
        hit  = 1'b0;
        if (req.restart) begin
            clear_shadow();
        end
        for (int b = 0; b < IDX_W; b++) begin
            if ((shadow_limit >> b) != 0) begin
                mask[b] = 1'b1;
            end
        end
        cand = req.random_word[IDX_W-1:0] & mask;
        for (int k = 0; k < shadow_count; k++) begin
            if (shadow_list[k] == cand) begin
                hit = 1'b1;
            end
        end
        res.accepted = (cand < shadow_limit) && !hit && (shadow_count < LIST_DEPTH);
        if (res.accepted) begin
            shadow_list[shadow_count] = cand;
            shadow_count++;
        end
        res.candidate_index = cand;
        res.stored_count    = OUT_CNT_W'(shadow_count);
        res.list_full       = (shadow_count == LIST_DEPTH);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // result side: random stall, check every taken result against the oldest prediction
    always @(posedge i_clk) begin
        t_dis_out exp_s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, o_out_data);
                mismatch_count++;
            end else begin
                exp_s = expected_samples.pop_front();
                check_field("accepted", 32'(exp_s.accepted), 32'(o_out_data.accepted));
                check_field("candidate_index", 32'(exp_s.candidate_index),
                            32'(o_out_data.candidate_index));
                check_field("stored_count", 32'(exp_s.stored_count),
                            32'(o_out_data.stored_count));
                check_field("list_full", 32'(exp_s.list_full), 32'(o_out_data.list_full));
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_word(input logic [WORD_W-1:0] word, input logic restart);
        t_dis_in req;
        req.random_word = word;
        req.restart     = restart;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_samples.push_back(predict_sample(req));
    endtask

    // every request yields a result, so an empty queue means the block is idle
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [IDX_W-1:0] lim);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        shadow_limit  = lim;
    endtask

    // reset limit: bounds, duplicate, masked top bits, restart
    task automatic test_reset_limit();
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFF0_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'(LIMIT_RESET - 1), 1'b0);
        send_word(32'(LIMIT_RESET), 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'h1234_0000 | 32'(LIMIT_RESET - 1), 1'b1);
    endtask

    task automatic test_limit_extremes();
        write_limit(LIMIT_MAX);
        send_word(32'hFFFF_FFFF, 1'b1);   // all-ones candidate is the marker, never valid
        send_word(32'hFFFF_FFFE, 1'b0);
        send_word(32'h000F_FFFE, 1'b0);
        write_limit(IDX_W'(2));
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h0000_0002, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFD, 1'b0);
        write_limit(IDX_W'(1));
        send_word(32'hFFFF_FFFE, 1'b1);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        write_limit(IDX_W'(0));
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);
    endtask

    // fill every slot, then offer new and repeated candidates to a full list
    task automatic test_full_list();
        write_limit(LIMIT_MAX);
        for (int k = 0; k < LIST_DEPTH + 3; k++) begin
            send_word({12'($urandom_range(4095)), IDX_W'(k * 3)}, k == 0);
        end
        send_word({12'($urandom_range(4095)), IDX_W'(15)}, 1'b0);
        send_word($urandom, 1'b1);
    endtask

    task automatic test_random(input int sender_pct, input int recv_pct, input int n_items);
        int               sent;
        int               block_len;
        logic [IDX_W-1:0] lim;
        logic [WORD_W-1:0] word;
        sent = 0;
        send_idle_pct  = sender_pct;
        recv_stall_pct = recv_pct;
        while (sent < n_items) begin
            case ($urandom_range(5))
                0:       lim = IDX_W'(2);
                1:       lim = IDX_W'($urandom_range(3, 300));
                2:       lim = LIMIT_RESET;
                3:       lim = LIMIT_MAX;
                4:       lim = IDX_W'(LIST_DEPTH + $urandom_range(0, 8));
                default: lim = IDX_W'($urandom_range(2, 2**IDX_W - 1));
            endcase
            write_limit(lim);
            block_len = $urandom_range(80, 220);
            for (int j = 0; j < block_len && sent < n_items; j++) begin
                case ($urandom_range(15))
                    0:       word = ($urandom & ~32'(LIMIT_MAX)) | 32'(lim - 1);
                    1:       word = ($urandom & ~32'(LIMIT_MAX)) | 32'(lim);
                    2:       word = 32'hFFFF_FFFF;
                    default: word = $urandom;
                endcase
                // a sequence opens with a restart; stray restarts are noise
                send_word(word, (j == 0) || ($urandom_range(49) == 0));
                sent++;
                if ($urandom_range(59) == 0) begin
                    settle();
                end
            end
        end
    endtask

    initial begin
        shadow_limit = LIMIT_RESET;
        clear_shadow();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 16;
        recv_stall_pct = 60;
        test_reset_limit();
        test_limit_extremes();
        test_full_list();
        test_random(16, 60, 260);
        test_random(60, 16, 260);
        test_random(0, 0, 260);

        settle();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (expected_samples.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, expected_samples.size());
            end
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("%0t: timeout", $time);
        $display("Verification failed");
        $finish;
    end

endmodule
